// ===== rtl/pbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbbs_pkg: shared types and constants for the position bitmap block
// Capacity, derived widths, item kinds, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pbbs_pkg;

  // Bitmap capacity in 32-bit words.
  localparam int WORDS   = 256;
  localparam int WORD_W  = 32;
  // Word address width (at least one bit).
  localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  // Bit offset width inside the span.
  localparam int OFF_W   = ADDR_W + 5;
  // Words-in-use width, holds 0..WORDS.
  localparam int LW_W    = $clog2(WORDS + 1);
  // Cursor width, holds 0..WORDS*32.
  localparam int CUR_W   = $clog2(WORDS * 32 + 1);
  // Reported count width.
  localparam int VALUE_W = 14;
  // Signed source word pointer width for the shift.
  localparam int SRC_W   = ADDR_W + 2;

  localparam logic [WORD_W-1:0] TOP_BIT = 32'h8000_0000;
  localparam logic [31:0]       SPAN    = 32'(WORDS * 32);

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_NEXT   = 2'd2,
    MODE_REWIND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_EVAL,
    S_ADD_RD,
    S_ADD_WR,
    S_SH_PRIME,
    S_SH_LOAD,
    S_SH_RUN,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/position_bitmap_builder_scanner.sv =====
// ----------------------------------------------------------------------------
// position_bitmap_builder_scanner: position bitmap with next-set-bit scan
// Keeps a bitmap of row positions relative to a start position, grows it at
// either end, and walks the set positions in ascending order.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: mode; tdata: position
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: next_position,
//          |     |                    |        value_count
//
//  An add before the start rewrites the whole bitmap, one word per cycle through
//  the single write port; a get-next reads words from the cursor word onward
//  until it finds a set bit or passes the last word in use.
//  Reset (rst, synchronous) empties the block at once: per-word valid flags
//  are cleared, so no clearing pass is needed.
//  The result sits in an output register; s_tready is high in the idle state
//  even while an earlier result waits for m_tready.
//
`default_nettype none

module position_bitmap_builder_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transactions
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] position
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  // result transactions
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] next_position, [45:32] value_count
  output logic [1:0]       m_tuser    // [1:0] status
);

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  pbbs_pkg::state_t            state, state_next;
  logic [31:0]                 start_pos;
  logic [31:0]                 end_pos;
  logic [pbbs_pkg::VALUE_W-1:0] set_count;
  logic [pbbs_pkg::LW_W-1:0]   last_word;
  logic [pbbs_pkg::CUR_W-1:0]  cursor;

  // Bitmap memory, per-word valid flags and registered read port
  logic [pbbs_pkg::WORD_W-1:0] mem [pbbs_pkg::WORDS];
  logic [pbbs_pkg::WORDS-1:0]  valid;
  logic [pbbs_pkg::WORD_W-1:0] mem_q;
  logic                        q_vld;    // read word was written and in range
  logic                        q_in;     // read address was in range
  logic                        mem_we;
  logic [pbbs_pkg::ADDR_W-1:0] mem_wa;
  logic [pbbs_pkg::WORD_W-1:0] mem_wd;
  logic [pbbs_pkg::ADDR_W-1:0] mem_ra;
  logic                        rd_in;

  // Working registers
  logic [31:0]                 in_pos;
  logic [pbbs_pkg::OFF_W-1:0]  off_reg;
  logic                        beyond;
  logic [pbbs_pkg::LW_W-1:0]   need;
  logic [4:0]                  sh_bs;
  logic [pbbs_pkg::SRC_W-1:0]  sh_src;
  logic [pbbs_pkg::ADDR_W-1:0] wi;
  logic [pbbs_pkg::WORD_W-1:0] hold;
  logic [pbbs_pkg::LW_W:0]     widx;
  logic [pbbs_pkg::LW_W:0]     rd_widx;
  logic                        rd_live;
  pbbs_pkg::status_t           res_status;
  logic [31:0]                 res_next;

  // Output register
  pbbs_pkg::status_t           out_status;
  logic [31:0]                 out_next;
  logic [pbbs_pkg::VALUE_W-1:0] out_count;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic            s_accept;
  logic            out_free;
  pbbs_pkg::mode_t in_mode;

  assign s_tready = (state == pbbs_pkg::S_IDLE);
  assign s_accept = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_mode  = pbbs_pkg::mode_t'(s_tuser);

  assign m_tdata  = {2'b00, out_count, out_next};
  assign m_tuser  = out_status;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [pbbs_pkg::WORD_W-1:0] cur_word;
  assign cur_word = q_vld ? mem_q : '0;

  // add evaluation: comparisons and distances, all against in_pos
  logic        pos_zero, lt_start, at_edge, lt_end;
  logic [31:0] diff_end, diff_start, off_full;
  assign pos_zero   = (in_pos == 32'd0);
  assign lt_start   = (in_pos < start_pos);
  assign at_edge    = (in_pos == start_pos) || (in_pos == end_pos);
  assign lt_end     = (in_pos < end_pos);
  assign diff_end   = end_pos - in_pos;
  assign diff_start = start_pos - in_pos;
  assign off_full   = in_pos - start_pos;

  // bit for an add, MSB first inside the word
  logic [pbbs_pkg::WORD_W-1:0] add_bit;
  assign add_bit = pbbs_pkg::TOP_BIT >> off_reg[4:0];

  // shift: merge held word and the one just read
  logic [pbbs_pkg::WORD_W-1:0] shw;
  always_comb begin
    shw = hold >> sh_bs;
    if (sh_bs != 5'd0) shw = shw | (cur_word << (6'd32 - {1'b0, sh_bs}));
    if (wi == '0) shw = shw | pbbs_pkg::TOP_BIT;
  end

  // scan: mask the cursor word, find the first set bit from the MSB
  logic [pbbs_pkg::WORD_W-1:0] masked;
  logic                        any_set;
  logic [4:0]                  lz;
  logic [pbbs_pkg::CUR_W-1:0]  found_off;
  always_comb begin
    masked = cur_word;
    if (rd_widx == {1'b0, cursor[pbbs_pkg::CUR_W-1:5]})
      masked = cur_word & (32'hFFFF_FFFF >> cursor[4:0]);
    any_set = (masked != '0);
    lz = 5'd0;
    for (int k = 0; k < pbbs_pkg::WORD_W; k++) begin
      if (masked[k]) lz = 5'(pbbs_pkg::WORD_W - 1 - k);
    end
  end
  assign found_off = pbbs_pkg::CUR_W'({rd_widx, lz});

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_ra     = '0;
    rd_in      = 1'b0;
    unique case (state)
      pbbs_pkg::S_IDLE: begin
        if (s_accept) begin
          unique case (in_mode)
            pbbs_pkg::MODE_BEGIN: begin
              mem_we     = 1'b1;
              mem_wd     = pbbs_pkg::TOP_BIT;
              state_next = pbbs_pkg::S_RESP;
            end
            pbbs_pkg::MODE_ADD:    state_next = pbbs_pkg::S_ADD_EVAL;
            pbbs_pkg::MODE_NEXT:   state_next = pbbs_pkg::S_SCAN;
            pbbs_pkg::MODE_REWIND: state_next = pbbs_pkg::S_RESP;
            default:               state_next = pbbs_pkg::S_RESP;
          endcase
        end
      end
      pbbs_pkg::S_ADD_EVAL: begin
        if (pos_zero) begin
          state_next = pbbs_pkg::S_RESP;
        end else if (lt_start) begin
          state_next = (diff_end >= pbbs_pkg::SPAN) ? pbbs_pkg::S_RESP
                                                    : pbbs_pkg::S_SH_PRIME;
        end else if (at_edge) begin
          state_next = pbbs_pkg::S_RESP;
        end else if (!lt_end && (off_full >= pbbs_pkg::SPAN)) begin
          state_next = pbbs_pkg::S_RESP;
        end else begin
          state_next = pbbs_pkg::S_ADD_RD;
        end
      end
      pbbs_pkg::S_ADD_RD: begin
        mem_ra     = off_reg[pbbs_pkg::OFF_W-1:5];
        rd_in      = 1'b1;
        state_next = pbbs_pkg::S_ADD_WR;
      end
      pbbs_pkg::S_ADD_WR: begin
        mem_wa = off_reg[pbbs_pkg::OFF_W-1:5];
        mem_wd = cur_word | add_bit;
        mem_we = beyond || ((cur_word & add_bit) == '0);
        state_next = pbbs_pkg::S_RESP;
      end
      pbbs_pkg::S_SH_PRIME: begin
        mem_ra     = sh_src[pbbs_pkg::ADDR_W-1:0];
        rd_in      = !sh_src[pbbs_pkg::SRC_W-1];
        state_next = pbbs_pkg::S_SH_LOAD;
      end
      pbbs_pkg::S_SH_LOAD: begin
        mem_ra     = sh_src[pbbs_pkg::ADDR_W-1:0];
        rd_in      = !sh_src[pbbs_pkg::SRC_W-1];
        state_next = pbbs_pkg::S_SH_RUN;
      end
      pbbs_pkg::S_SH_RUN: begin
        mem_ra = sh_src[pbbs_pkg::ADDR_W-1:0];
        rd_in  = !sh_src[pbbs_pkg::SRC_W-1];
        mem_we = 1'b1;
        mem_wa = wi;
        mem_wd = shw;
        if (wi == '0) state_next = pbbs_pkg::S_RESP;
      end
      pbbs_pkg::S_SCAN: begin
        mem_ra = widx[pbbs_pkg::ADDR_W-1:0];
        rd_in  = (widx < {1'b0, last_word});
        if (rd_live && (!q_in || any_set)) state_next = pbbs_pkg::S_RESP;
      end
      pbbs_pkg::S_RESP: begin
        if (out_free) state_next = pbbs_pkg::S_IDLE;
      end
      default: state_next = pbbs_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Bitmap memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      q_vld <= 1'b0;
      q_in  <= 1'b0;
    end else begin
      // begin empties the store; word 0 is then written with the first bit
      if (s_accept && (in_mode == pbbs_pkg::MODE_BEGIN)) valid <= '0;
      if (mem_we) valid[mem_wa] <= 1'b1;
      q_vld <= valid[mem_ra] & rd_in;
      q_in  <= rd_in;
    end
  end

  // --------------------------------------------------------------------------
  // Block state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= '0;
      end_pos   <= '0;
      set_count <= '0;
      last_word <= '0;
      cursor    <= '0;
      m_tvalid  <= 1'b0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= (state == pbbs_pkg::S_SCAN);
      if (state == pbbs_pkg::S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        pbbs_pkg::S_IDLE: begin
          if (s_accept) begin
            if (in_mode == pbbs_pkg::MODE_BEGIN) begin
              start_pos <= s_tdata;
              end_pos   <= s_tdata;
              set_count <= pbbs_pkg::VALUE_W'(1);
              last_word <= pbbs_pkg::LW_W'(1);
              cursor    <= '0;
            end else if (in_mode == pbbs_pkg::MODE_REWIND) begin
              cursor <= '0;
            end
          end
        end
        pbbs_pkg::S_ADD_WR: begin
          if (beyond || ((cur_word & add_bit) == '0))
            set_count <= set_count + pbbs_pkg::VALUE_W'(1);
          if (beyond) begin
            end_pos   <= in_pos;
            last_word <= need;
          end
        end
        pbbs_pkg::S_SH_RUN: begin
          if (wi == '0) begin
            start_pos <= in_pos;
            set_count <= set_count + pbbs_pkg::VALUE_W'(1);
            last_word <= need;
          end
        end
        pbbs_pkg::S_SCAN: begin
          if (rd_live && q_in && any_set)
            cursor <= found_off + pbbs_pkg::CUR_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    unique case (state)
      pbbs_pkg::S_IDLE: begin
        in_pos     <= s_tdata;
        res_status <= pbbs_pkg::ST_OK;
        res_next   <= '0;
        widx       <= {1'b0, cursor[pbbs_pkg::CUR_W-1:5]};
      end
      pbbs_pkg::S_ADD_EVAL: begin
        off_reg <= off_full[pbbs_pkg::OFF_W-1:0];
        beyond  <= !lt_end;
        sh_bs   <= diff_start[4:0];
        sh_src  <= pbbs_pkg::SRC_W'(pbbs_pkg::WORDS - 1)
                 - pbbs_pkg::SRC_W'(diff_start[pbbs_pkg::OFF_W-1:5]);
        wi      <= pbbs_pkg::ADDR_W'(pbbs_pkg::WORDS - 1);
        if (lt_start)
          need <= pbbs_pkg::LW_W'(diff_end[pbbs_pkg::OFF_W-1:5]) + pbbs_pkg::LW_W'(1);
        else
          need <= pbbs_pkg::LW_W'(off_full[pbbs_pkg::OFF_W-1:5]) + pbbs_pkg::LW_W'(1);
        if (pos_zero)
          res_status <= pbbs_pkg::ST_ZERO;
        else if (lt_start && (diff_end >= pbbs_pkg::SPAN))
          res_status <= pbbs_pkg::ST_FULL;
        else if (!lt_start && !at_edge && !lt_end && (off_full >= pbbs_pkg::SPAN))
          res_status <= pbbs_pkg::ST_FULL;
      end
      pbbs_pkg::S_SH_PRIME: begin
        sh_src <= sh_src - pbbs_pkg::SRC_W'(1);
      end
      pbbs_pkg::S_SH_LOAD: begin
        sh_src <= sh_src - pbbs_pkg::SRC_W'(1);
        hold   <= cur_word;
      end
      pbbs_pkg::S_SH_RUN: begin
        sh_src <= sh_src - pbbs_pkg::SRC_W'(1);
        hold   <= cur_word;
        wi     <= wi - pbbs_pkg::ADDR_W'(1);
      end
      pbbs_pkg::S_SCAN: begin
        widx    <= widx + (pbbs_pkg::LW_W + 1)'(1);
        rd_widx <= widx;
        if (rd_live) begin
          if (!q_in) begin
            res_status <= pbbs_pkg::ST_EMPTY;
          end else if (any_set) begin
            res_next <= start_pos + 32'(found_off);
          end
        end
      end
      pbbs_pkg::S_RESP: begin
        if (out_free) begin
          out_status <= res_status;
          out_next   <= res_next;
          out_count  <= set_count;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_position_bitmap_builder_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_position_bitmap_builder_scanner: self-checking bench for the position bitmap
// Directed cases hit the empty block, 32-bit extremes, capacity limits and
// front growth under a live cursor. Random sequences follow: a begin, then
// mixed adds, get-next walks and rewinds. Every accepted transaction goes
// through an in-bench predictor, and each result is compared against the
// oldest pending prediction. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------

module tb_position_bitmap_builder_scanner;

  // result fields as carried on m_tuser / m_tdata
  typedef struct packed {
    pbbs_pkg::status_t status;
    logic [31:0]       next_pos;
    logic [13:0]       count;
  } bitmap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] position
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] next_position, [45:32] value_count
  logic [1:0]  m_tuser;        // [1:0] status

  position_bitmap_builder_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: bitmap relative to base_pos, MSB of word 0 = offset 0
  // --------------------------------------------------------------------------
  logic [31:0] pos_words [pbbs_pkg::WORDS];
  logic [31:0] base_pos;
  logic [31:0] top_pos;
  logic [31:0] pos_count;
  logic [31:0] words_used;
  logic [31:0] scan_cursor;

  bitmap_result_t pending_results [$];
  int             mismatches = 0;

  initial begin
    for (int i = 0; i < pbbs_pkg::WORDS; i++) pos_words[i] = '0;
    base_pos    = '0;
    top_pos     = '0;
    pos_count   = '0;
    words_used  = '0;
    scan_cursor = '0;
  end

  // Move every bit d offsets further from the base (plain shift, d < span).
  function automatic void shift_positions(logic [31:0] d);
    int          ws;
    int          bs;
    int          src;
    logic [31:0] v;
    ws = int'(d >> 5);
    bs = int'(d & 32'd31);
    for (int i = pbbs_pkg::WORDS - 1; i >= 0; i--) begin
      v = '0;
      if (i >= ws) begin
        src = i - ws;
        v = pos_words[src] >> bs;
        if (bs != 0 && src >= 1) v |= pos_words[src-1] << (32 - bs);
      end
      pos_words[i] = v;
    end
  endfunction

  function automatic pbbs_pkg::status_t add_position(logic [31:0] pos);
    logic [31:0] need;
    logic [31:0] off;
    logic [31:0] idx;
    if (pos == 0) return pbbs_pkg::ST_ZERO;
    if (pos < base_pos) begin
      // growth at the front: rebase, cursor offset kept as is
      need = (top_pos - pos) / 32 + 1;
      if (need > 32'(pbbs_pkg::WORDS)) return pbbs_pkg::ST_FULL;
      shift_positions(base_pos - pos);
      base_pos     = pos;
      pos_words[0] = pos_words[0] | pbbs_pkg::TOP_BIT;
      pos_count++;
      words_used   = need;
      return pbbs_pkg::ST_OK;
    end
    if (pos == base_pos || pos == top_pos) return pbbs_pkg::ST_OK;
    off = pos - base_pos;
    idx = (off >> 5) % pbbs_pkg::WORDS;
    if (pos < top_pos) begin
      if ((pos_words[idx] & (pbbs_pkg::TOP_BIT >> off[4:0])) == 0) begin
        pos_words[idx] = pos_words[idx] | (pbbs_pkg::TOP_BIT >> off[4:0]);
        pos_count++;
      end
      return pbbs_pkg::ST_OK;
    end
    need = off / 32 + 1;
    if (need > 32'(pbbs_pkg::WORDS)) return pbbs_pkg::ST_FULL;
    pos_words[idx] = pos_words[idx] | (pbbs_pkg::TOP_BIT >> off[4:0]);
    top_pos    = pos;
    words_used = need;
    pos_count++;
    return pbbs_pkg::ST_OK;
  endfunction

  function automatic pbbs_pkg::status_t scan_next(output logic [31:0] found);
    logic [31:0] limit;
    logic [31:0] o;
    logic [31:0] masked;
    logic [4:0]  b;
    found = '0;
    limit = words_used * 32;
    o     = scan_cursor;
    while (o < limit) begin
      masked = pos_words[(o >> 5) % pbbs_pkg::WORDS] & (32'hFFFF_FFFF >> o[4:0]);
      if (masked != 0) begin
        b = o[4:0];
        while ((masked & (pbbs_pkg::TOP_BIT >> b)) == 0) b++;
        o           = {o[31:5], 5'd0} + 32'(b);
        found       = base_pos + o;
        scan_cursor = o + 1;
        return pbbs_pkg::ST_OK;
      end
      o = {o[31:5], 5'd0} + 32;
    end
    return pbbs_pkg::ST_EMPTY;
  endfunction

  function automatic bitmap_result_t predict_result(pbbs_pkg::mode_t mode,
                                                    logic [31:0] pos);
    bitmap_result_t r;
    r.status   = pbbs_pkg::ST_OK;
    r.next_pos = '0;
    case (mode)
      pbbs_pkg::MODE_BEGIN: begin
        for (int i = 0; i < pbbs_pkg::WORDS; i++) pos_words[i] = '0;
        pos_words[0] = pbbs_pkg::TOP_BIT;
        base_pos     = pos;
        top_pos      = pos;
        pos_count    = 1;
        words_used   = 1;
        scan_cursor  = 0;
      end
      pbbs_pkg::MODE_ADD:  r.status = add_position(pos);
      pbbs_pkg::MODE_NEXT: r.status = scan_next(r.next_pos);
      default:             scan_cursor = 0;
    endcase
    r.count = pos_count[13:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("[%0t] mismatch #%0d on %s: expected 0x%08h, got 0x%08h",
             $realtime, mismatches, field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: outputs checked first, then the accepted input is predicted.
  // Both sampled at the edge, before any NBA update of this step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bitmap_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, m_tdata[31:0]);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.status)
            report_mismatch("status", 32'(want.status), 32'(m_tuser));
          if (m_tdata[31:0] != want.next_pos)
            report_mismatch("next_position", want.next_pos, m_tdata[31:0]);
          if (m_tdata[45:32] != want.count)
            report_mismatch("value_count", 32'(want.count), 32'(m_tdata[45:32]));
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_result(pbbs_pkg::mode_t'(s_tuser), s_tdata));
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: styles of stalling that change now and then; a hold-off
  // request from a test keeps m_tready low for a counted stretch.
  // --------------------------------------------------------------------------
  int hold_request = 0;
  int hold_left    = 0;
  int stall_style  = 0;
  int style_left   = 0;
  int rx_phase     = 0;

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 200);
      end
      style_left--;
      rx_phase++;
      case (stall_style)
        0:       m_tready <= 1'b1;                         // no stalls
        1:       m_tready <= $urandom_range(0, 1) == 1;    // coin flip
        2:       m_tready <= $urandom_range(0, 3) == 0;    // mostly stalled
        default: m_tready <= (rx_phase % 5) < 3;           // periodic on/off pattern
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps with junk on the bus
  // --------------------------------------------------------------------------
  logic offer_on   = 1'b0;
  int   burst_left = 0;

  task automatic send_item(pbbs_pkg::mode_t mode, logic [31:0] pos);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= pos;
    offer_on = 1'b1;
    do @(posedge clk); while (!s_tready);
    // transaction accepted at this edge
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        s_tuser  <= 2'($urandom);
        offer_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender pauses until every predicted result has come back
  task automatic drain_results();
    if (offer_on) begin
      s_tvalid <= 1'b0;
      offer_on = 1'b0;
    end
    // step one edge first so the monitor has logged the last acceptance
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // no begin yet: block starts empty at zero and grows from there
  task automatic test_empty_block();
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_ADD, 32'd0);                  // zero rejected
    send_item(pbbs_pkg::MODE_ADD, 32'd5);
    send_item(pbbs_pkg::MODE_ADD, 32'd8191);               // exactly full span
    send_item(pbbs_pkg::MODE_ADD, 32'd8192);               // one past capacity
    send_item(pbbs_pkg::MODE_REWIND, 32'hFFFF_FFFF);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_NEXT, 32'hFFFF_FFFF);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);                 // exhausted
    drain_results();
  endtask

  // top of the 32-bit range, front growth to full capacity, duplicates
  task automatic test_position_extremes();
    send_item(pbbs_pkg::MODE_BEGIN, 32'hFFFF_FFFF);
    send_item(pbbs_pkg::MODE_ADD, 32'hFFFF_FFFF);          // at start and end
    send_item(pbbs_pkg::MODE_ADD, 32'hFFFF_E000);          // grow front to full span
    send_item(pbbs_pkg::MODE_ADD, 32'hFFFF_DFFF);          // front growth too wide
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_ADD, 32'hFFFF_F000);
    send_item(pbbs_pkg::MODE_ADD, 32'hFFFF_F000);          // already set
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    drain_results();
  endtask

  // cursor keeps its offset when the front moves under it
  task automatic test_front_growth_cursor();
    send_item(pbbs_pkg::MODE_BEGIN, 32'd1000);
    send_item(pbbs_pkg::MODE_ADD, 32'd1040);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_ADD, 32'd990);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_REWIND, 32'd0);
    send_item(pbbs_pkg::MODE_NEXT, 32'd0);
    send_item(pbbs_pkg::MODE_BEGIN, 32'd0);
    send_item(pbbs_pkg::MODE_ADD, 32'd0);
    drain_results();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_backpressure();
    hold_request = 300;
    burst_left   = 40;
    send_item(pbbs_pkg::MODE_BEGIN, 32'd64);
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_item(pbbs_pkg::MODE_NEXT, $urandom);
      else            send_item(pbbs_pkg::MODE_ADD, 32'd64 + $urandom_range(0, 200));
    end
    drain_results();
  endtask

  // random sequences: begin, then mostly well-formed adds and walks
  task automatic test_random_sequences(int total);
    int          sent;
    int          seq_len;
    int          pick;
    logic [31:0] seq_base;
    logic [31:0] window;
    logic [31:0] last_add;
    logic [31:0] pos;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 3))
        0:       seq_base = $urandom;
        1:       seq_base = $urandom_range(1, 100);
        2:       seq_base = 32'hFFFF_FFFF - $urandom_range(0, 9000);
        default: seq_base = $urandom_range(1000, 1_000_000);
      endcase
      case ($urandom_range(0, 5))
        0:       window = 8191;
        1, 2:    window = 300;
        default: window = 40;
      endcase
      last_add = seq_base;
      send_item(pbbs_pkg::MODE_BEGIN, seq_base);
      sent++;
      seq_len = $urandom_range(5, 60);
      for (int k = 0; k < seq_len && sent < total; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          pick = $urandom_range(0, 99);
          if (pick < 60)      pos = seq_base + $urandom_range(0, window);
          else if (pick < 75) pos = seq_base - $urandom_range(1, window / 2 + 1);
          else if (pick < 80) pos = seq_base + 8192 + $urandom_range(0, 100);
          else if (pick < 83) pos = 32'd0;
          else if (pick < 88) pos = $urandom;
          else                pos = last_add;
          last_add = pos;
          send_item(pbbs_pkg::MODE_ADD, pos);
        end else if (pick < 85) begin
          send_item(pbbs_pkg::MODE_NEXT, $urandom);
        end else if (pick < 92) begin
          send_item(pbbs_pkg::MODE_REWIND, $urandom);
        end else begin
          send_item(pbbs_pkg::mode_t'($urandom_range(0, 3)), $urandom);
        end
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_block();
    test_position_extremes();
    test_front_growth_cursor();
    test_output_backpressure();
    test_random_sequences(850);
    // worst-case latency of one transaction plus margin
    repeat (pbbs_pkg::WORDS + 16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
